@@ hw/rtl/fixed_key_spn_block_encrypt_defines.svh @@
// Assertion macros used by the checker file of the block.
`ifndef FIXED_KEY_SPN_BLOCK_ENCRYPT_DEFINES_SVH
`define FIXED_KEY_SPN_BLOCK_ENCRYPT_DEFINES_SVH

// Same-cycle implication, off during reset.
`define FKSPN_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, off during reset.
`define FKSPN_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication that also holds across reset.
`define FKSPN_ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

@@ hw/rtl/fkspn_pkg.sv @@
// Package: types, constants, S-box and round-key ROM of the SPN block.
package fkspn_pkg;

  localparam int STEP_COUNT_DEF = 132;
  localparam int KEY_ROM_SIZE   = 132;
  localparam int KEY_IDX_W      = 8;   // holds any step up to 255
  localparam int BLOCK_W        = 64;
  localparam int WORD_W         = 16;

  typedef logic [3:0][WORD_W-1:0] word_set_t;

  localparam logic [3:0] SBOX [16] = '{
    4'hc, 4'h5, 4'h6, 4'hb, 4'h9, 4'h0, 4'ha, 4'hd,
    4'h3, 4'he, 4'hf, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  localparam logic [WORD_W-1:0] KEY_ROM [KEY_ROM_SIZE] = '{
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'hcc00, 16'h0000, 16'h0000, 16'h0000, 16'hc300,
    16'h0000, 16'h0000, 16'h0000, 16'h5b30, 16'h0001, 16'h0000, 16'h0000, 16'h580c,
    16'h0001, 16'h0000, 16'hc000, 16'h656c, 16'h0001, 16'h0000, 16'h3000, 16'h6e60,
    16'h0001, 16'h0000, 16'hb300, 16'hb595, 16'h0002, 16'h0000, 16'h80c0, 16'hbeb9,
    16'h0002, 16'h0000, 16'h56cc, 16'h96d6, 16'h0002, 16'h0000, 16'he603, 16'h9ffa,
    16'h0002, 16'h3000, 16'h595b, 16'h065b, 16'h0003, 16'h0c00, 16'heb98, 16'h0f7f,
    16'h0003, 16'h6cc0, 16'h6d65, 16'hac19, 16'h0003, 16'h6030, 16'hffae, 16'ha33d,
    16'h0003, 16'h95b3, 16'h65b5, 16'hd6b0, 16'hc004, 16'hb980, 16'hf7fe, 16'hdf8c,
    16'hcc04, 16'hd656, 16'hc196, 16'h3b5a, 16'h0304, 16'hfae6, 16'h33df, 16'h387e,
    16'h5b34, 16'h5b59, 16'h6b06, 16'heced, 16'h9809, 16'h7feb, 16'hf8cf, 16'he3e1,
    16'h6569, 16'h196d, 16'hb5ac, 16'h6bb3, 16'hae65, 16'h3dff, 16'h87e3, 16'hbb8f,
    16'hb590, 16'hb065, 16'hced6, 16'h80ae, 16'hfebf, 16'h8cf7, 16'h3e1f, 16'hc1ee,
    16'h96d0, 16'h5ac1, 16'hbb3b, 16'h2602, 16'hdffc, 16'h7e33, 16'hb8f8, 16'hcb07,
    16'h065d, 16'hed6b, 16'h0aec, 16'h3498, 16'hcf78, 16'he1f8, 16'h1ee3, 16'h8b2c,
    16'hac1e, 16'hb3b5, 16'h602b, 16'h54d2, 16'he33a, 16'h8f87, 16'hb07b, 16'h4a2c,
    16'hd6b7, 16'haece, 16'h4980, 16'h9753
  };

  function automatic logic [3:0] sbox(input logic [3:0] x);
    return SBOX[x];
  endfunction

  // Keys past the end of the ROM read as zero.
  function automatic logic [WORD_W-1:0] round_key(input logic [KEY_IDX_W-1:0] idx);
    logic [WORD_W-1:0] k;
    k = '0;
    if (int'(idx) < KEY_ROM_SIZE) begin
      k = KEY_ROM[idx];
    end
    return k;
  endfunction

endpackage

@@ hw/rtl/fkspn_if.sv @@
// Stream interfaces for the plaintext input and the ciphertext output.
interface fkspn_plain_if import fkspn_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BLOCK_W-1:0] plain_block;

  modport source (output valid, output plain_block, input ready);
  modport sink   (input valid, input plain_block, output ready);
endinterface

interface fkspn_cipher_if import fkspn_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BLOCK_W-1:0] cipher_block;

  modport source (output valid, output cipher_block, input ready);
  modport sink   (input valid, input cipher_block, output ready);
endinterface

@@ hw/rtl/fkspn_round.sv @@
// Shared round unit: gather slice, key XOR, four S-boxes, transposed write-back.
module fkspn_round import fkspn_pkg::*; (
  input  word_set_t            w_in,
  input  logic [KEY_IDX_W-1:0] step,
  output word_set_t            w_out
);

  logic [1:0]        s;
  logic              word_rnd;
  logic [WORD_W-1:0] slice;
  logic [WORD_W-1:0] subst;

  // d = step - 4: low bits of d equal step[1:0], bit 2 of d is ~step[2]
  assign s        = step[1:0];
  assign word_rnd = ~step[2];

  always_comb begin
    slice = '0;
    if (word_rnd) begin
      slice = w_in[s];
    end else begin
      for (int j = 0; j < 4; j++) begin
        slice[4*j +: 4] = w_in[j][{s, 2'b00} +: 4];
      end
    end
    slice = slice ^ round_key(step);
    for (int j = 0; j < 4; j++) begin
      subst[4*j +: 4] = sbox(slice[4*j +: 4]);
    end
  end

  always_comb begin
    w_out = w_in;
    for (int j = 0; j < 4; j++) begin
      for (int u = 0; u < 4; u++) begin
        if (word_rnd) begin
          w_out[s][4*u + j] = subst[4*j + u];
        end else begin
          w_out[u][{s, 2'(j)}] = subst[4*j + u];
        end
      end
    end
  end

endmodule

@@ hw/rtl/fixed_key_spn_block_encrypt.sv @@
// Top level: fixed-key SPN block encryptor with one shared round unit.
//
// Encrypts one 64-bit plaintext block per transfer on the plain channel and
// returns one 64-bit ciphertext block on the cipher channel. The key is fixed:
// round keys come from a constant ROM inside the block, so there is no key or
// configuration port. On accept the plaintext nibbles are scattered into four
// 16-bit words; then one round unit (slice gather, key XOR, four S-boxes,
// transposed write-back) runs one round per clock, followed by a final
// step that XORs the output keys into the result register. plain.ready is
// high only while the sequencer is idle, so a new block is accepted only
// after the previous one has passed the final step. The result register is
// separate from the working words: the next block is accepted and processed
// while an earlier result still waits on cipher.ready; only the final
// key-XOR step stalls if the previous result has not been taken yet.
// Reset (rst, synchronous, active high) clears the sequencer and the result
// valid flag; no cipher state survives between blocks.
module fixed_key_spn_block_encrypt import fkspn_pkg::*; #(
  parameter int STEP_COUNT = STEP_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  fkspn_plain_if.sink           plain,
  fkspn_cipher_if.source        cipher
);

  localparam int STEP_W = $clog2(STEP_COUNT);
  localparam logic [STEP_W-1:0]    FIRST_STEP = STEP_W'(4);
  localparam logic [STEP_W-1:0]    LAST_STEP  = STEP_W'(STEP_COUNT - 5);
  localparam logic [KEY_IDX_W-1:0] KEY_BASE   = KEY_IDX_W'(STEP_COUNT - 4);
  localparam bit                   HAS_ROUNDS = (STEP_COUNT > 8);

  // one-hot sequencer
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ROUND = 3'b010,
    ST_FIN   = 3'b100
  } state_t;

  state_t             state, state_next;
  word_set_t          w, w_next;       // working words
  word_set_t          w_round;         // round unit result
  logic [STEP_W-1:0]  step, step_next;
  logic [BLOCK_W-1:0] out_data, out_data_next;
  logic               out_valid;
  logic               in_xfer;
  logic               out_load;

  assign in_xfer  = plain.valid && plain.ready;
  // result register free, or being emptied this cycle
  assign out_load = (state == ST_FIN) && (!out_valid || cipher.ready);

  fkspn_round u_round (
    .w_in  (w),
    .step  (KEY_IDX_W'(step)),
    .w_out (w_round)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = HAS_ROUNDS ? ST_ROUND : ST_FIN;
        end
      end
      ST_ROUND: begin
        if (step == LAST_STEP) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    w_next    = w;
    step_next = step;
    if (state == ST_IDLE) begin
      // word i, nibble j <- plaintext nibble 4j+i
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          w_next[i][4*j +: 4] = plain.plain_block[16*j + 4*i +: 4];
        end
      end
      step_next = FIRST_STEP;
    end else if (state == ST_ROUND) begin
      w_next    = w_round;
      step_next = step + STEP_W'(1);
    end
  end

  // output whitening with the last four round keys
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      out_data_next[WORD_W*k +: WORD_W] = w[k] ^ round_key(KEY_BASE + KEY_IDX_W'(k));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (cipher.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer || state == ST_ROUND) begin
      w    <= w_next;
      step <= step_next;
    end
    if (out_load) begin
      out_data <= out_data_next;
    end
  end

  assign plain.ready         = (state == ST_IDLE);
  assign cipher.valid        = out_valid;
  assign cipher.cipher_block = out_data;

endmodule

@@ hw/rtl/fkspn_checker.sv @@
// Port-level checker for the SPN block encryptor, bound to the top level.
`include "fixed_key_spn_block_encrypt_defines.svh"

module fkspn_checker import fkspn_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               plain_valid,
  input logic               plain_ready,
  input logic               cipher_valid,
  input logic               cipher_ready,
  input logic [BLOCK_W-1:0] cipher_block
);

  logic       in_xfer;
  logic       out_xfer;
  logic       out_stall;
  logic [1:0] pending;   // blocks accepted but not yet delivered

  assign in_xfer   = plain_valid && plain_ready;
  assign out_xfer  = cipher_valid && cipher_ready;
  assign out_stall = cipher_valid && !cipher_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_xfer) - 2'(out_xfer);
    end
  end

  `FKSPN_ASSERT_IMP(a_no_orphan_out, clk, rst, out_xfer, pending != 2'd0)
  `FKSPN_ASSERT_IMP(a_max_two_in_flight, clk, rst, in_xfer, pending != 2'd2 || out_xfer)
  `FKSPN_ASSERT_NXT(a_busy_after_in, clk, rst, in_xfer, !plain_ready)
  `FKSPN_ASSERT_NXT(a_out_hold, clk, rst, out_stall, cipher_valid && $stable(cipher_block))
  `FKSPN_ASSERT_NXT_ALWAYS(a_reset_empty, clk, rst, !cipher_valid)

endmodule

bind fixed_key_spn_block_encrypt fkspn_checker u_fkspn_checker (
  .clk          (clk),
  .rst          (rst),
  .plain_valid  (plain.valid),
  .plain_ready  (plain.ready),
  .cipher_valid (cipher.valid),
  .cipher_ready (cipher.ready),
  .cipher_block (cipher.cipher_block)
);
